@@ src/bcf_pkg.sv @@
// Shared widths, defaults, controller states and command/status types of the flattener.
package bcf_pkg;

  localparam int HandleW         = 16;
  localparam int PointW          = 24;
  localparam int InDataW         = 2 * HandleW;
  localparam int OutDataW        = 2 * PointW;
  localparam int DefMaxSamples   = 64;
  localparam int DefMaxHandles   = 1024;
  localparam int DefTFracBits    = 16;
  localparam int PointFracBits   = 8;
  localparam int PipeWaitCycles  = 3;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIST  = 8'b0000_0010,
    S_SQRT  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_TINIT = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_EMIT0 = 8'b1000_0000
  } bcf_state_e;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic div_step;
    logic t_init;
    logic t_next;
    logic emit_pt;
    logic emit_p0;
  } bcf_cmd_t;

  typedef struct packed {
    logic seg_go;
    logic c_zero;
    logic last_smp;
    logic out_free;
  } bcf_stat_t;

endpackage

@@ src/bcf_ctrl.sv @@
// Sequencer of the flattener: handle intake, distance, divider setup and sample emission.
module bcf_ctrl import bcf_pkg::*; #(
  parameter int MAX_SAMPLES = DefMaxSamples,
  parameter int T_FRAC_BITS = DefTFracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bcf_stat_t stat_i,
  output bcf_cmd_t  cmd_o
);

  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W = $clog2(T_FRAC_BITS + 2);

  bcf_state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && stat_i.seg_go) begin
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        state_d = S_SQRT;
        cnt_d   = '0;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(CW - 1)) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(T_FRAC_BITS)) begin
          // The sample count is settled once the root is done.
          state_d = stat_i.c_zero ? S_EMIT0 : S_TINIT;
          cnt_d   = '0;
        end
      end
      S_TINIT: begin
        cmd_o.t_init = 1'b1;
        state_d = S_WAIT;
        cnt_d   = '0;
      end
      S_WAIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(PipeWaitCycles - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          if (stat_i.last_smp) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.t_next = 1'b1;
            state_d = S_WAIT;
            cnt_d   = '0;
          end
        end
      end
      S_EMIT0: begin
        if (stat_i.out_free) begin
          cmd_o.emit_p0 = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ src/bcf_datapath.sv @@
// Datapath: handle window, distance and root, step divider, Bernstein pipeline, output register.
module bcf_datapath import bcf_pkg::*; #(
  parameter int MAX_SAMPLES = DefMaxSamples,
  parameter int MAX_HANDLES = DefMaxHandles,
  parameter int T_FRAC_BITS = DefTFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_last_i,
  input  bcf_cmd_t            cmd_i,
  output bcf_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_seg_end_o,
  output logic                out_outline_end_o
);

  localparam int F      = T_FRAC_BITS;
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int HCW    = $clog2(MAX_HANDLES + 1);
  localparam int D2W    = 2 * HandleW + 2;
  localparam int BW     = F + 2;
  localparam int PRW    = 2 * F + 5;
  localparam int CPW    = BW + 1 + HandleW;
  localparam int SW     = CPW + 2;
  localparam int HALF_T = 1 << (F - 1);
  localparam int HSH    = (F > 8) ? F - 9 : 0;
  localparam int HALF_O = (F > 8) ? (1 << HSH) : 0;
  localparam int OSH    = F - PointFracBits;
  localparam logic [D2W-1:0] MaxSq = D2W'(MAX_SAMPLES * MAX_SAMPLES);
  localparam logic signed [SW-1:0] OutMax = SW'((1 << (PointW - 1)) - 1);
  localparam logic signed [SW-1:0] OutMin = -SW'(1 << (PointW - 1));

  logic signed [HandleW-1:0] in_x, in_y;
  assign in_x = in_data_i[HandleW-1:0];
  assign in_y = in_data_i[InDataW-1:HandleW];

  // Outline bookkeeping: handles taken so far and their position modulo three.
  logic [HCW-1:0] hcnt_q;
  logic [1:0]     ph_q;
  logic signed [HandleW-1:0] first_x_q [2];
  logic signed [HandleW-1:0] first_y_q [2];
  logic signed [HandleW-1:0] win_x_q [3];
  logic signed [HandleW-1:0] win_y_q [3];
  logic full, anchor_go, close_go;

  assign full      = (hcnt_q == HCW'(MAX_HANDLES));
  assign anchor_go = !full && (ph_q == 2'd1) && (hcnt_q >= HCW'(4));
  assign close_go  = !full && in_last_i && (ph_q == 2'd2) && (hcnt_q >= HCW'(5));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
      ph_q   <= '0;
      for (int i = 0; i < 2; i++) begin
        first_x_q[i] <= '0;
        first_y_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      if (full) begin
        if (in_last_i) begin
          hcnt_q <= '0;
          ph_q   <= '0;
        end
      end else begin
        if (hcnt_q == '0) begin
          first_x_q[0] <= in_x;
          first_y_q[0] <= in_y;
        end
        if (hcnt_q == HCW'(1)) begin
          first_x_q[1] <= in_x;
          first_y_q[1] <= in_y;
        end
        win_x_q[0] <= win_x_q[1];
        win_y_q[0] <= win_y_q[1];
        win_x_q[1] <= win_x_q[2];
        win_y_q[1] <= win_y_q[2];
        win_x_q[2] <= in_x;
        win_y_q[2] <= in_y;
        hcnt_q <= in_last_i ? '0 : hcnt_q + 1'b1;
        ph_q   <= (in_last_i || ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
      end
    end
  end

  // Control points of the segment under work.
  logic signed [HandleW-1:0] px_q [4];
  logic signed [HandleW-1:0] py_q [4];
  logic closing_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      closing_q <= close_go;
      if (close_go) begin
        px_q[0] <= win_x_q[2];  py_q[0] <= win_y_q[2];
        px_q[1] <= in_x;        py_q[1] <= in_y;
        px_q[2] <= first_x_q[0]; py_q[2] <= first_y_q[0];
        px_q[3] <= first_x_q[1]; py_q[3] <= first_y_q[1];
      end else begin
        px_q[0] <= win_x_q[0];  py_q[0] <= win_y_q[0];
        px_q[1] <= win_x_q[1];  py_q[1] <= win_y_q[1];
        px_q[2] <= win_x_q[2];  py_q[2] <= win_y_q[2];
        px_q[3] <= in_x;        py_q[3] <= in_y;
      end
    end
  end

  // Squared anchor distance, then a bit-serial root over the few bits the count needs.
  logic signed [HandleW:0]     dx, dy;
  logic signed [2*HandleW+1:0] sqx, sqy;
  logic [D2W-1:0] d2_q;
  logic           sat_q;
  logic [CW-1:0]  root_q, mask_q, cand, cnt_c;
  logic [2*CW-1:0] cand_sq;

  assign dx  = (HandleW + 1)'(px_q[3]) - (HandleW + 1)'(px_q[0]);
  assign dy  = (HandleW + 1)'(py_q[3]) - (HandleW + 1)'(py_q[0]);
  assign sqx = (2 * HandleW + 2)'(dx) * (2 * HandleW + 2)'(dy - dy + dx);
  assign sqy = (2 * HandleW + 2)'(dy) * (2 * HandleW + 2)'(dy);
  assign cand    = root_q | mask_q;
  assign cand_sq = (2 * CW)'(cand) * (2 * CW)'(cand);
  assign cnt_c   = sat_q ? CW'(MAX_SAMPLES) : root_q;

  always_ff @(posedge clk_i) begin
    d2_q  <= D2W'(sqx) + D2W'(sqy);
    sat_q <= (D2W'(sqx) + D2W'(sqy)) >= MaxSq;
    if (cmd_i.load) begin
      root_q <= '0;
      mask_q <= CW'(1) << (CW - 1);
    end else if (cmd_i.sqrt_step) begin
      if (D2W'(cand_sq) <= d2_q) begin
        root_q <= cand;
      end
      mask_q <= mask_q >> 1;
    end
  end

  // Restoring divider for one step 2^F / (count + 1): quotient and remainder.
  logic [CW:0]   dv, rem_q;
  logic [CW+1:0] rem_sh;
  logic [F:0]    quo_q;
  logic          first_q, qbit;

  assign dv     = (CW + 1)'(cnt_c) + 1'b1;
  assign rem_sh = {rem_q, first_q};
  assign qbit   = rem_sh >= (CW + 2)'(dv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q   <= '0;
      quo_q   <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      rem_q   <= qbit ? (CW + 1)'(rem_sh - (CW + 2)'(dv)) : rem_sh[CW:0];
      quo_q   <= {quo_q[F-1:0], qbit};
      first_q <= 1'b0;
    end
  end

  // Sample parameter t advanced by quotient and remainder with one carry fix-up.
  logic [F-1:0]  t_q;
  logic [CW:0]   r_q;
  logic [CW-1:0] k_q;
  logic [CW+1:0] rsum;
  logic          rcarry;

  assign rsum   = (CW + 2)'(r_q) + (CW + 2)'(rem_q);
  assign rcarry = rsum >= (CW + 2)'(dv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_init) begin
      t_q <= '0;
      r_q <= dv >> 1;
      k_q <= '0;
    end else if (cmd_i.t_next) begin
      t_q <= t_q + quo_q[F-1:0] + F'(rcarry);
      r_q <= rcarry ? (CW + 1)'(rsum - (CW + 2)'(dv)) : rsum[CW:0];
      k_q <= k_q + 1'b1;
    end
  end

  // Bernstein weights and point products, one multiply level per stage.
  logic [F:0]   u;
  logic [F-1:0] t1_q;
  logic [F:0]   u1_q, tt_q, uu_q;
  logic [PRW-1:0] m_tt, m_uu, m_b0, m_b1, m_b2, m_b3;
  logic [BW-1:0]  b_q [4];
  logic signed [CPW-1:0] cx_q [4];
  logic signed [CPW-1:0] cy_q [4];

  assign u    = (F + 1)'(1 << F) - (F + 1)'(t_q);
  assign m_tt = (PRW'(t_q) * PRW'(t_q) + PRW'(HALF_T)) >> F;
  assign m_uu = (PRW'(u) * PRW'(u) + PRW'(HALF_T)) >> F;
  assign m_b0 = (PRW'(uu_q) * PRW'(u1_q) + PRW'(HALF_T)) >> F;
  assign m_b1 = (PRW'(PRW'(t1_q) * PRW'(3)) * PRW'(uu_q) + PRW'(HALF_T)) >> F;
  assign m_b2 = (PRW'(PRW'(tt_q) * PRW'(3)) * PRW'(u1_q) + PRW'(HALF_T)) >> F;
  assign m_b3 = (PRW'(tt_q) * PRW'(t1_q) + PRW'(HALF_T)) >> F;

  always_ff @(posedge clk_i) begin
    t1_q <= t_q;
    u1_q <= u;
    tt_q <= m_tt[F:0];
    uu_q <= m_uu[F:0];
    b_q[0] <= m_b0[BW-1:0];
    b_q[1] <= m_b1[BW-1:0];
    b_q[2] <= m_b2[BW-1:0];
    b_q[3] <= m_b3[BW-1:0];
    for (int i = 0; i < 4; i++) begin
      cx_q[i] <= $signed({1'b0, b_q[i]}) * CPW'(px_q[i]);
      cy_q[i] <= $signed({1'b0, b_q[i]}) * CPW'(py_q[i]);
    end
  end

  logic signed [SW-1:0] sum_x, sum_y, sh_x, sh_y;
  logic [PointW-1:0] sat_x, sat_y;

  assign sum_x = SW'(cx_q[0]) + SW'(cx_q[1]) + SW'(cx_q[2]) + SW'(cx_q[3]);
  assign sum_y = SW'(cy_q[0]) + SW'(cy_q[1]) + SW'(cy_q[2]) + SW'(cy_q[3]);
  assign sh_x  = (sum_x + SW'(HALF_O)) >>> OSH;
  assign sh_y  = (sum_y + SW'(HALF_O)) >>> OSH;

  always_comb begin
    sat_x = sh_x[PointW-1:0];
    if (sh_x > OutMax) sat_x = OutMax[PointW-1:0];
    if (sh_x < OutMin) sat_x = OutMin[PointW-1:0];
    sat_y = sh_y[PointW-1:0];
    if (sh_y > OutMax) sat_y = OutMax[PointW-1:0];
    if (sh_y < OutMin) sat_y = OutMin[PointW-1:0];
  end

  // Output register; it holds while the receiver stalls.
  logic last_smp;
  assign last_smp = (CW'(k_q + 1'b1) == cnt_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_pt || cmd_i.emit_p0) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pt) begin
      out_data_o        <= {sat_y, sat_x};
      out_seg_end_o     <= last_smp;
      out_outline_end_o <= closing_q && last_smp;
    end else if (cmd_i.emit_p0) begin
      out_data_o        <= {py_q[0], 8'h00, px_q[0], 8'h00};
      out_seg_end_o     <= 1'b1;
      out_outline_end_o <= closing_q;
    end
  end

  assign stat_o.seg_go   = anchor_go || close_go;
  assign stat_o.c_zero   = (cnt_c == '0);
  assign stat_o.last_smp = last_smp;
  assign stat_o.out_free = !out_valid_o || out_ready_i;

endmodule

@@ src/closed_cubic_bezier_flattener_core.sv @@
// Top level of the closed cubic Bezier outline flattener.
// Handle points enter on the slave stream, one request per handle, in the order
// pre-control, anchor, post-control; s_axis_tlast marks the last handle of an outline.
// Each anchor from the second on, and the last handle of a complete outline,
// starts one cubic segment whose sampled points leave on the master stream.
// m_axis_tuser flags the last point of a segment, m_axis_tlast the last point
// of the closing segment.
// A handle that starts no segment is taken without leaving the idle state. Segment
// setup runs the distance, a CW-step root with CW = clog2(MAX_SAMPLES+1), the
// bit-serial step divider and the t start; each point then passes the three
// multiplier stages of the weight pipeline and the output register, and the next
// point starts only once the current one is emitted.
// The slave side is not ready while a segment is being sampled.
// When the receiver stalls, the point stays in the output register and sampling
// pauses until it is taken. Reset clears the handle count and the stored handles.
module closed_cubic_bezier_flattener_core import bcf_pkg::*; #(
  parameter int MAX_SAMPLES = DefMaxSamples,
  parameter int MAX_HANDLES = DefMaxHandles,
  parameter int T_FRAC_BITS = DefTFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // handle_x [15:0], handle_y [31:16]
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // point_x [23:0], point_y [47:24]
  output logic                m_axis_tuser,  // segment_end
  output logic                m_axis_tlast
);

  bcf_cmd_t  cmd;
  bcf_stat_t stat;

  bcf_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bcf_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .MAX_HANDLES(MAX_HANDLES),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_data_i         (s_axis_tdata),
    .in_last_i         (s_axis_tlast),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_data_o        (m_axis_tdata),
    .out_seg_end_o     (m_axis_tuser),
    .out_outline_end_o (m_axis_tlast)
  );

endmodule

@@ verif/closed_cubic_bezier_flattener_core_test.sv @@
// Self-checking testbench for the closed cubic Bezier outline flattener core.
module closed_cubic_bezier_flattener_core_test;
  import bcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RunLimit   = 10_000_000;
  localparam int  RandomReqs = 420;

  typedef struct {
    logic [PointW-1:0] x;
    logic [PointW-1:0] y;
    logic              seg_end;
    logic              outline_end;
  } curve_pt_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  curve_pt_t pending_pts[$];
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_left = 0;
  int        rdy_gap_left = 0;
  bit        no_idle = 1'b0;

  // Model copy of the handle store
  int        first_xy[4];
  int        recent_xy[6];
  int        handles_seen;

  closed_cubic_bezier_flattener_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [PointW-1:0] clamp24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[PointW-1:0];
  endfunction

  function automatic longint unsigned round_t(longint unsigned v);
    return (v + (64'd1 << (DefTFracBits - 1))) >> DefTFracBits;
  endfunction

  // Samples one cubic and queues its points; p holds x0,y0 .. x3,y3.
  function automatic void sample_cubic(int p[8], bit closing);
    longint          dx;
    longint          dy;
    longint unsigned cnt;
    longint unsigned one;
    longint unsigned t;
    longint unsigned u;
    longint unsigned tt;
    longint unsigned uu;
    longint unsigned w[4];
    longint          sx;
    longint          sy;
    curve_pt_t       pt;
    dx = longint'(p[6]) - p[0];
    dy = longint'(p[7]) - p[1];
    cnt = int_sqrt(dx * dx + dy * dy);
    one = 64'd1 << DefTFracBits;
    if (cnt > DefMaxSamples) cnt = DefMaxSamples;
    if (cnt == 0) begin
      pt.x = clamp24(longint'(p[0]) * 256);
      pt.y = clamp24(longint'(p[1]) * 256);
      pt.seg_end = 1'b1;
      pt.outline_end = closing;
      pending_pts.push_back(pt);
      return;
    end
    for (longint unsigned k = 0; k < cnt; k++) begin
      t = (k * one + (cnt + 1) / 2) / (cnt + 1);
      u = one - t;
      tt = round_t(t * t);
      uu = round_t(u * u);
      w[0] = round_t(uu * u);
      w[1] = round_t(3 * t * uu);
      w[2] = round_t(3 * tt * u);
      w[3] = round_t(tt * t);
      sx = 0;
      sy = 0;
      for (int i = 0; i < 4; i++) begin
        sx += longint'(w[i]) * p[2*i];
        sy += longint'(w[i]) * p[2*i+1];
      end
      sx = (sx + (64'sd1 << (DefTFracBits - 9))) >>> (DefTFracBits - PointFracBits);
      sy = (sy + (64'sd1 << (DefTFracBits - 9))) >>> (DefTFracBits - PointFracBits);
      pt.x = clamp24(sx);
      pt.y = clamp24(sy);
      pt.seg_end = (k + 1 == cnt);
      pt.outline_end = closing && (k + 1 == cnt);
      pending_pts.push_back(pt);
    end
  endfunction

  function automatic void predict_handle(logic [HandleW-1:0] hx, logic [HandleW-1:0] hy,
                                         logic lst);
    int x;
    int y;
    int n;
    int p[8];
    x = int'($signed(hx));
    y = int'($signed(hy));
    if (handles_seen >= DefMaxHandles) begin
      if (lst) handles_seen = 0;
      return;
    end
    n = handles_seen + 1;
    if (n >= 5 && n % 3 == 2) begin
      for (int i = 0; i < 6; i++) p[i] = recent_xy[i];
      p[6] = x;
      p[7] = y;
      sample_cubic(p, 1'b0);
    end
    // The closing cubic runs from the last anchor back to the first anchor.
    if (lst && n >= 6 && n % 3 == 0) begin
      p[0] = recent_xy[4];
      p[1] = recent_xy[5];
      p[2] = x;
      p[3] = y;
      for (int i = 0; i < 4; i++) p[4+i] = first_xy[i];
      sample_cubic(p, 1'b1);
    end
    if (n <= 2) begin
      first_xy[(n-1)*2] = x;
      first_xy[(n-1)*2+1] = y;
    end
    for (int i = 0; i < 4; i++) recent_xy[i] = recent_xy[i+2];
    recent_xy[4] = x;
    recent_xy[5] = y;
    handles_seen = lst ? 0 : n;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_handle(logic [HandleW-1:0] hx, logic [HandleW-1:0] hy, logic lst);
    int gap;
    s_axis_tdata  <= {hy, hx};
    s_axis_tlast  <= lst;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_handle(hx, hy, lst);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_points();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_pts.size() != 0);
    repeat (PipeWaitCycles + 4) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_handle(16'h8000, 16'h8000, 1'b0);
    send_handle(16'h7fff, 16'h7fff, 1'b0);
    send_handle(16'h8000, 16'h7fff, 1'b0);
    send_handle(16'h7fff, 16'h8000, 1'b0);
    send_handle(16'h0000, 16'h0000, 1'b0);
    send_handle(16'hffff, 16'hffff, 1'b1);
    // Coincident anchors give a single point per segment.
    for (int i = 0; i < 6; i++) send_handle(16'd5, -16'sd5, i == 5);
    // Short anchor-to-anchor hops give a handful of samples.
    send_handle(16'd1, 16'd2, 1'b0);
    send_handle(16'd3, 16'd0, 1'b0);
    send_handle(16'd7, 16'd3, 1'b0);
    send_handle(-16'sd9, 16'd6, 1'b0);
    send_handle(16'd10, 16'd7, 1'b0);
    send_handle(16'd0, 16'd4, 1'b1);
    wait_all_points();
  endtask

  task automatic test_short_outlines();
    send_handle(16'd100, 16'd100, 1'b1);
    for (int i = 0; i < 4; i++) send_handle(16'(i * 50), 16'(-i * 30), i == 3);
    for (int i = 0; i < 5; i++) send_handle(16'(i * 20), 16'(i * 7), i == 4);
    for (int i = 0; i < 7; i++) send_handle(16'(i * 3), 16'(i * 11), i == 6);
    wait_all_points();
  endtask

  task automatic test_random_outlines();
    int sent;
    int len;
    int near;
    int bx;
    int by;
    sent = 0;
    while (sent < RandomReqs) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 8) len = 3 * $urandom_range(2, 8);
      else len = $urandom_range(1, 20);
      near = ($urandom_range(0, 1) == 0);
      bx = $urandom_range(0, 65535) - 32768;
      by = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < len; i++) begin
        if (near)
          send_handle(16'(bx + $urandom_range(0, 80) - 40),
                      16'(by + $urandom_range(0, 80) - 40), i == len - 1);
        else
          send_handle(16'($urandom), 16'($urandom), i == len - 1);
      end
      sent += len;
    end
    no_idle = 1'b0;
    wait_all_points();
  endtask

  task automatic test_backpressure();
    hold_left = 1500;
    no_idle = 1'b1;
    for (int i = 0; i < 9; i++) send_handle(16'($urandom), 16'($urandom), i == 8);
    no_idle = 1'b0;
    wait_all_points();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_gap_left > 0) begin
      rdy_gap_left <= rdy_gap_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        rdy_gap_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(20, 60);
    end
  end

  always @(posedge clk_i) begin
    curve_pt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h", $time, m_axis_tdata[23:0],
                 m_axis_tdata[47:24]);
        fail_cnt++;
      end else begin
        want = pending_pts.pop_front();
        if (m_axis_tdata[23:0] !== want.x) begin
          $display("%0t: point_x expected %h actual %h", $time, want.x, m_axis_tdata[23:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[47:24] !== want.y) begin
          $display("%0t: point_y expected %h actual %h", $time, want.y, m_axis_tdata[47:24]);
          fail_cnt++;
        end
        if (m_axis_tuser !== want.seg_end) begin
          $display("%0t: segment_end expected %b actual %b", $time, want.seg_end,
                   m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tlast !== want.outline_end) begin
          $display("%0t: outline_end expected %b actual %b", $time, want.outline_end,
                   m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RunLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) first_xy[i] = 0;
    for (int i = 0; i < 6; i++) recent_xy[i] = 0;
    handles_seen = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_short_outlines();
    test_backpressure();
    test_random_outlines();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending_pts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ closed_cubic_bezier_flattener_core.f @@
src/bcf_pkg.sv
src/bcf_ctrl.sv
src/bcf_datapath.sv
src/closed_cubic_bezier_flattener_core.sv
verif/closed_cubic_bezier_flattener_core_test.sv
